[hdl/msx_pkg.sv]
`default_nettype none
package msx_pkg;
  localparam int MaxSeedBytes = 64;
  localparam int SeedAw = $clog2(MaxSeedBytes);
  localparam int SeedCw = $clog2(MaxSeedBytes + 1);
  localparam int DigestBytes = 20;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       end_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] masked_byte;
    logic       masked_last;
  } out_item_t;

  typedef struct packed {
    logic seed_clear;
    logic seed_wr;
    logic msg_clear;
    logic hash_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic digest_empty;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] i);
    if (i < 7'd20) return 32'h5A827999;
    else if (i < 7'd40) return 32'h6ED9EBA1;
    else if (i < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    if (i < 7'd20) return (b & c) | (~b & d);
    else if (i < 7'd40) return b ^ c ^ d;
    else if (i < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction
endpackage
`default_nettype wire

[hdl/mgf1_sha1_mask_xor_unit.sv]
// MGF1 (SHA-1) mask XOR unit. Seed bytes are stored in a 64-entry buffer. A message
// byte is accepted, emitted and its result handed off when mask bytes remain in the
// current digest. Every 20th byte first runs one SHA-1 over seed||counter on a single
// round unit, one 64-byte block at a time (one block for seeds up to 51 bytes, two
// above). The input transaction is held in a register during the work, so in_ready
// is low until the result is taken.
`default_nettype none
module mgf1_sha1_mask_xor_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  msx_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output msx_pkg::out_item_t    out_data
);
  import msx_pkg::*;

  in_item_t item_r;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  in_item_t dp_item;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
  end

  assign dp_item = (in_valid && in_ready) ? in_data : item_r;

  msx_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data(dp_item),
    .out_valid, .out_ready, .sts, .cmd
  );

  msx_datapath u_dp (
    .clk, .rst_n, .cmd, .item(dp_item), .sts, .res(out_data)
  );
endmodule
`default_nettype wire

[hdl/msx_datapath.sv]
`default_nettype none
module msx_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  msx_pkg::dp_cmd_t     cmd,
  input  msx_pkg::in_item_t    item,
  output msx_pkg::dp_sts_t     sts,
  output msx_pkg::out_item_t   res
);
  import msx_pkg::*;

  typedef enum logic [2:0] {H_IDLE, H_LOAD, H_RND, H_ADD, H_DONE} hstate_t;

  logic [7:0]        seed_mem [MaxSeedBytes];
  logic [SeedCw-1:0] seed_count_r;
  logic [31:0]       counter_r;
  logic [159:0]      digest_r;
  logic [4:0]        offset_r;
  out_item_t         res_r;

  hstate_t           hst_r;
  logic [31:0]       h_r [5];
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [31:0]       w_r [16];
  logic [6:0]        rnd_r;
  logic [5:0]        bi_r;
  logic [7:0]        pos_r;
  logic [7:0]        total_r;
  logic [7:0]        len_r;
  logic [7:0]        rd_r;
  logic              last_blk_r;

  logic [7:0]  len_c, total_c, p_c, v_c, rel_c, blen_c;
  logic [63:0] bits_c;
  logic [31:0] wi_c, t_c;
  logic [SeedCw-1:0] seed_base_c;
  logic              seed_we_c;
  logic [SeedAw-1:0] rd_addr_c;

  assign len_c   = 8'(seed_count_r) + 8'd4;
  assign total_c = ((len_c + 8'd8) >> 6) * 8'd64 + 8'd64;
  assign p_c     = pos_r;
  assign bits_c  = 64'(len_r) << 3;
  assign rel_c   = total_r - 8'd1 - p_c;

  assign seed_base_c = cmd.seed_clear ? '0 : seed_count_r;
  assign seed_we_c   = cmd.seed_wr && (seed_base_c < SeedCw'(MaxSeedBytes));
  assign rd_addr_c   = (hst_r == H_IDLE) ? SeedAw'(0)
                       : pos_r[SeedAw-1:0] + ((hst_r == H_LOAD && bi_r != 6'd63) ?
                                              SeedAw'(1) : SeedAw'(0));

  always_comb begin
    blen_c = 8'd0;
    if (p_c < len_r - 8'd4) v_c = rd_r;
    else if (p_c < len_r) begin
      blen_c = p_c - (len_r - 8'd4);
      case (blen_c[1:0])
        2'd0: v_c = counter_r[31:24];
        2'd1: v_c = counter_r[23:16];
        2'd2: v_c = counter_r[15:8];
        default: v_c = counter_r[7:0];
      endcase
    end else if (p_c == len_r) v_c = 8'h80;
    else if (p_c >= total_r - 8'd8) v_c = 8'(bits_c >> (8 * rel_c[2:0]));
    else v_c = 8'h00;
  end

  assign wi_c = (rnd_r < 7'd16) ? w_r[rnd_r[3:0]]
                : rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 5'd1);
  assign t_c  = rotl(a_r, 5'd5) + round_f(rnd_r, b_r, c_r, d_r) + e_r
                + round_k(rnd_r) + wi_c;

  always_ff @(posedge clk) begin
    if (seed_we_c)
      seed_mem[seed_base_c[SeedAw-1:0]] <= item.data_byte;
    rd_r <= seed_mem[rd_addr_c];
    if (cmd.out_load) begin
      res_r.masked_byte <= item.data_byte ^ digest_r[159 - 8*offset_r -: 8];
      res_r.masked_last <= item.end_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= '0;
      counter_r    <= '0;
      offset_r     <= 5'(DigestBytes);
      hst_r        <= H_IDLE;
      digest_r     <= '0;
    end else begin
      if (cmd.seed_clear || cmd.msg_clear) begin
        counter_r    <= '0;
        offset_r     <= 5'(DigestBytes);
      end else if (cmd.out_load) begin
        offset_r <= offset_r + 5'd1;
      end
      if (seed_we_c)
        seed_count_r <= seed_base_c + SeedCw'(1);
      else if (cmd.seed_clear || cmd.msg_clear)
        seed_count_r <= '0;
      case (hst_r)
        H_IDLE: if (cmd.hash_start) begin
          h_r[0] <= 32'h67452301; h_r[1] <= 32'hEFCDAB89; h_r[2] <= 32'h98BADCFE;
          h_r[3] <= 32'h10325476; h_r[4] <= 32'hC3D2E1F0;
          len_r   <= len_c;
          total_r <= total_c;
          pos_r   <= '0;
          bi_r    <= '0;
          hst_r   <= H_LOAD;
        end
        H_LOAD: begin
          w_r[bi_r[5:2]] <= {w_r[bi_r[5:2]][23:0], v_c};
          pos_r <= pos_r + 8'd1;
          bi_r  <= bi_r + 6'd1;
          if (bi_r == 6'd63) begin
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
            rnd_r <= '0;
            last_blk_r <= (pos_r + 8'd1 == total_r);
            hst_r <= H_RND;
          end
        end
        H_RND: begin
          e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 5'd30); b_r <= a_r; a_r <= t_c;
          if (rnd_r >= 7'd16) begin
            for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
            w_r[15] <= wi_c;
          end else if (rnd_r == 7'd15) begin
            // keep window aligned: rounds 0..15 index directly
          end
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) hst_r <= H_ADD;
        end
        H_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          bi_r <= '0;
          hst_r <= last_blk_r ? H_DONE : H_LOAD;
        end
        H_DONE: begin
          digest_r  <= {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
          counter_r <= counter_r + 32'd1;
          offset_r  <= '0;
          hst_r     <= H_IDLE;
        end
        default: hst_r <= H_IDLE;
      endcase
    end
  end

  assign sts.hash_done    = (hst_r == H_DONE);
  assign sts.digest_empty = (offset_r >= 5'(DigestBytes));
  assign res = res_r;
endmodule
`default_nettype wire

[hdl/msx_ctrl.sv]
`default_nettype none
module msx_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  msx_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  input  msx_pkg::dp_sts_t    sts,
  output msx_pkg::dp_cmd_t    cmd
);
  import msx_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_WAIT, S_EMIT} state_t;

  state_t state_r;
  logic   seed_done_r;
  logic   out_valid_r;
  logic   acc;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.seed_clear = acc && !in_data.req_type && seed_done_r;
    cmd.seed_wr    = acc && !in_data.req_type;
    cmd.hash_start = (state_r == S_HASH);
    cmd.out_load   = (state_r == S_EMIT);
    cmd.msg_clear  = (state_r == S_EMIT) && in_data.end_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc) begin
          if (!in_data.req_type) begin
            seed_done_r <= in_data.end_flag;
          end else begin
            seed_done_r <= 1'b1;
            state_r <= sts.digest_empty ? S_HASH : S_EMIT;
          end
        end
        S_HASH: state_r <= S_WAIT;
        S_WAIT: if (sts.hash_done) state_r <= S_EMIT;
        S_EMIT: begin
          out_valid_r <= 1'b1;
          if (in_data.end_flag) seed_done_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
